### rtl/lkm_pkg.sv
// shared types and constants of the led keypad two-wire master
package lkm_pkg;

    typedef enum logic [1:0] {
        OP_TICK        = 2'd0,
        OP_SETTINGS    = 2'd1,
        OP_WRITE_DIGIT = 2'd2,
        OP_READ_KEYS   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_BRIGHTNESS   = 2'd0,
        CFG_SEVEN_SEG    = 2'd1,
        CFG_LOW_POWER    = 2'd2,
        CFG_DISPLAY_ON   = 2'd3
    } cfg_index_t;

    localparam logic [7:0] CMD_SETTINGS  = 8'h48;
    localparam logic [7:0] CMD_READ_KEYS = 8'h4F;
    localparam logic [7:0] DIGIT_BASE    = 8'h68;
    localparam logic [6:0] LAST_WRITE    = 7'd58;
    localparam logic [6:0] LAST_READ     = 7'd50;

    typedef struct packed {
        op_t        op;
        logic [1:0] digit;
        logic [7:0] segment_pattern;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       key_valid;
        logic [7:0] key_code;
        logic       ack_missing;
    } out_item_t;

    typedef struct packed {
        logic [2:0] brightness;
        logic       seven_segment_mode;
        logic       low_power;
        logic       display_on;
    } cfg_t;

    typedef struct packed {
        logic [6:0] tick_step;
        op_t        transaction_kind;
        logic [7:0] shift_byte;
        logic [7:0] second_byte;
        logic [7:0] received_key;
        logic       nack_seen;
        logic [1:0] line_levels;
    } lkm_state_t;

    function automatic logic [7:0] settings_byte(input cfg_t c);
        settings_byte = {1'b0, c.brightness, c.seven_segment_mode, c.low_power,
                         1'b0, c.display_on};
    endfunction

endpackage

### rtl/lkm_tick.sv
// per-tick line sequencing: next state and line levels for one half-bit tick
module lkm_tick import lkm_pkg::*; (
    input  lkm_state_t state_i,
    input  in_item_t   item_i,
    input  cfg_t       cfg_i,
    output lkm_state_t state_o,
    output out_item_t  result_o
);

    lkm_state_t st;
    logic       scl;
    logic       sda;
    logic [6:0] p;
    logic [6:0] last;
    logic [6:0] s;
    logic [6:0] q7;
    logic [4:0] q;
    logic [8:0] prod;
    logic [3:0] bit_idx;
    logic [4:0] sub5;
    logic [1:0] sub;
    logic       rd;
    logic       reload;

    always_comb begin
        st       = state_i;
        result_o = '0;
        scl      = 1'b1;
        sda      = 1'b1;
        p        = '0;
        last     = LAST_WRITE;
        s        = '0;
        q7       = '0;
        q        = '0;
        prod     = '0;
        bit_idx  = '0;
        sub5     = '0;
        sub      = '0;
        rd       = 1'b0;
        reload   = 1'b0;

        // request on an idle tick
        if (st.tick_step == 7'd0 && item_i.op != OP_TICK) begin
            st.transaction_kind = item_i.op;
            unique case (item_i.op)
                OP_SETTINGS: begin
                    st.shift_byte  = CMD_SETTINGS;
                    st.second_byte = settings_byte(cfg_i);
                end
                OP_WRITE_DIGIT: begin
                    st.shift_byte  = DIGIT_BASE + {5'd0, item_i.digit, 1'b0};
                    st.second_byte = item_i.segment_pattern;
                end
                OP_READ_KEYS: begin
                    st.shift_byte  = CMD_READ_KEYS;
                    st.second_byte = 8'd0;
                end
                default: begin
                    st.shift_byte  = state_i.shift_byte;
                    st.second_byte = state_i.second_byte;
                end
            endcase
            st.nack_seen    = 1'b0;
            st.received_key = 8'd0;
            st.tick_step    = 7'd1;
        end

        if (st.tick_step == 7'd0) begin
            scl = st.line_levels[1];
            sda = st.line_levels[0];
        end else begin
            p    = st.tick_step - 7'd1;
            rd   = (st.transaction_kind == OP_READ_KEYS);
            last = rd ? LAST_READ : LAST_WRITE;
            result_o.busy_res = 1'b1;
            if (p >= last - 7'd2) begin
                // stop
                s   = p - (last - 7'd2);
                scl = (s >= 7'd1);
                sda = (s >= 7'd2);
            end else if (p < 7'd2) begin
                // start
                scl = (p == 7'd0);
                sda = 1'b0;
            end else if (p < 7'd29 || !rd) begin
                // written byte and its ack slot
                q7      = (p < 7'd29) ? (p - 7'd2) : (p - 7'd29);
                q       = q7[4:0];
                reload  = (p < 7'd29) && !rd;
                if (q < 5'd24) begin
                    prod    = 9'(q) * 9'd11;
                    bit_idx = prod[8:5];
                    sub5    = q - {bit_idx, 1'b0} - {1'b0, bit_idx};
                    sub     = sub5[1:0];
                    scl     = (sub == 2'd1);
                    sda     = st.shift_byte[7];
                    if (sub == 2'd2) begin
                        if (bit_idx == 4'd7) begin
                            sda = 1'b1;
                        end
                        st.shift_byte = {st.shift_byte[6:0], 1'b0};
                    end
                end else begin
                    scl = (q == 5'd25);
                    sda = 1'b1;
                    if (q == 5'd25 && item_i.sda_in) begin
                        st.nack_seen = 1'b1;
                    end
                    if (q == 5'd26 && reload) begin
                        st.shift_byte = st.second_byte;
                    end
                end
            end else if (p < 7'd45) begin
                // key read bits
                sda = 1'b1;
                if (!p[0]) begin
                    scl = 1'b0;
                end else begin
                    scl = 1'b1;
                    st.received_key = {st.received_key[6:0], item_i.sda_in};
                end
            end else begin
                // master not-ack
                scl = (p == 7'd46);
                sda = 1'b1;
            end

            if (p >= last) begin
                result_o.done_res = 1'b1;
                if (rd) begin
                    result_o.key_valid = 1'b1;
                    result_o.key_code  = st.received_key;
                end
                st.tick_step = 7'd0;
                scl = 1'b1;
                sda = 1'b1;
            end else begin
                st.tick_step = st.tick_step + 7'd1;
            end
        end

        st.line_levels       = {scl, sda};
        result_o.scl         = scl;
        result_o.sda_out     = sda;
        result_o.ack_missing = st.nack_seen;
        state_o              = st;
    end

endmodule

### rtl/led_keypad_two_wire_master.sv
// top level of the led keypad two-wire master: registers, handshakes and settings
// Each transfer on the s_ channel is one half-bit tick of the bus timer and yields exactly one
// result transfer on the m_ channel carrying the scl and sda drive levels for that tick plus
// busy, done, key and ack status. The block takes one tick per clock cycle while m_ready does
// not hold back the result; a tick passes through the input register, then the result register,
// before its result is offered on m_, and the tick sequencer between them is combinational.
// Write transactions span 59 ticks and a key read 51 ticks. Settings are written through the
// cfg_ port and sampled when a send settings request starts.
module led_keypad_two_wire_master import lkm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  logic [7:0] cfg_data
);

    logic       in_vld_reg;
    logic       in_vld_next;
    in_item_t   in_item_reg;
    logic       out_vld_reg;
    logic       out_vld_next;
    out_item_t  out_item_reg;
    lkm_state_t state_reg;
    lkm_state_t state_next;
    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    out_item_t  result;
    logic       advance;

    lkm_tick u_tick (
        .state_i  (state_reg),
        .item_i   (in_item_reg),
        .cfg_i    (cfg_reg),
        .state_o  (state_next),
        .result_o (result)
    );

    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_item_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_ready) begin
            in_vld_next = s_valid;
        end
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BRIGHTNESS: cfg_next.brightness         = cfg_data[2:0];
                CFG_SEVEN_SEG:  cfg_next.seven_segment_mode = cfg_data[0];
                CFG_LOW_POWER:  cfg_next.low_power          = cfg_data[0];
                CFG_DISPLAY_ON: cfg_next.display_on         = cfg_data[0];
                default:        cfg_next                    = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            cfg_reg     <= '0;
            state_reg   <= '{tick_step: 7'd0, transaction_kind: OP_TICK, shift_byte: 8'd0,
                             second_byte: 8'd0, received_key: 8'd0, nack_seen: 1'b0,
                             line_levels: 2'b11};
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            cfg_reg     <= cfg_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

endmodule

### sim/led_keypad_two_wire_master_tb.sv
// self-checking testbench of the led keypad two-wire master with a tick-level bus predictor
module led_keypad_two_wire_master_tb;
    import lkm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ItemBits = $bits(in_item_t);

    typedef enum {ACKS_LOW, ACKS_RANDOM, ACKS_HIGH} ack_mode_t;

    class tick_scoreboard;
        logic [2:0] brightness;
        logic       seven_seg;
        logic       low_power;
        logic       display_on;
        logic [6:0] step;
        op_t        kind;
        logic [7:0] shift_byte;
        logic [7:0] second_byte;
        logic [7:0] key_byte;
        logic       nack;
        logic [1:0] lines;
        out_item_t  expected_q[$];
        int         failures;
        int         results_seen;

        function new();
            brightness = '0;
            seven_seg = 1'b0;
            low_power = 1'b0;
            display_on = 1'b0;
            step = '0;
            kind = OP_TICK;
            shift_byte = '0;
            second_byte = '0;
            key_byte = '0;
            nack = 1'b0;
            lines = 2'b11;
            failures = 0;
            results_seen = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [7:0] value);
            case (idx)
                CFG_BRIGHTNESS: brightness = value[2:0];
                CFG_SEVEN_SEG:  seven_seg = value[0];
                CFG_LOW_POWER:  low_power = value[0];
                CFG_DISPLAY_ON: display_on = value[0];
                default: ;
            endcase
        endfunction

        // one tick of a written byte followed by its ack slot, q in 0..26
        function void byte_slot(int q, logic sda_in, bit reload,
                                output logic scl, output logic sda);
            int a;
            if (q < 24) begin
                scl = (q % 3 == 1);
                sda = shift_byte[7];
                if (q % 3 == 2) begin
                    if (q / 3 == 7)
                        sda = 1'b1;
                    shift_byte = {shift_byte[6:0], 1'b0};
                end
            end else begin
                a = q - 24;
                scl = (a == 1);
                sda = 1'b1;
                if (a == 1 && sda_in)
                    nack = 1'b1;
                if (a == 2 && reload)
                    shift_byte = second_byte;
            end
        endfunction

        function void note_tick(in_item_t it);
            out_item_t r;
            logic      scl_v;
            logic      sda_v;
            int        p;
            int        s;
            int        last;
            bit        rd;
            r = '0;
            scl_v = 1'b1;
            sda_v = 1'b1;
            if (step == 0 && it.op != OP_TICK) begin
                kind = it.op;
                case (it.op)
                    OP_SETTINGS: begin
                        shift_byte = CMD_SETTINGS;
                        second_byte = {1'b0, brightness, seven_seg, low_power,
                                       1'b0, display_on};
                    end
                    OP_WRITE_DIGIT: begin
                        shift_byte = DIGIT_BASE + {5'd0, it.digit, 1'b0};
                        second_byte = it.segment_pattern;
                    end
                    default: begin
                        shift_byte = CMD_READ_KEYS;
                        second_byte = '0;
                    end
                endcase
                nack = 1'b0;
                key_byte = '0;
                step = 7'd1;
            end
            if (step == 0) begin
                scl_v = lines[1];
                sda_v = lines[0];
            end else begin
                p = int'(step) - 1;
                rd = (kind == OP_READ_KEYS);
                last = rd ? int'(LAST_READ) : int'(LAST_WRITE);
                r.busy_res = 1'b1;
                if (p >= last - 2) begin
                    s = p - (last - 2);
                    scl_v = (s >= 1);
                    sda_v = (s >= 2);
                end else if (p < 2) begin
                    scl_v = (p == 0);
                    sda_v = 1'b0;
                end else if (p < 29) begin
                    byte_slot(p - 2, it.sda_in, !rd, scl_v, sda_v);
                end else if (!rd) begin
                    byte_slot(p - 29, it.sda_in, 1'b0, scl_v, sda_v);
                end else if (p < 45) begin
                    sda_v = 1'b1;
                    if (((p - 29) % 2) == 0) begin
                        scl_v = 1'b1;
                        key_byte = {key_byte[6:0], it.sda_in};
                    end else begin
                        scl_v = 1'b0;
                    end
                end else begin
                    scl_v = (p - 45 == 1);
                    sda_v = 1'b1;
                end
                if (p >= last) begin
                    r.done_res = 1'b1;
                    if (rd) begin
                        r.key_valid = 1'b1;
                        r.key_code = key_byte;
                    end
                    step = '0;
                    scl_v = 1'b1;
                    sda_v = 1'b1;
                end else begin
                    step = step + 7'd1;
                end
            end
            lines = {scl_v, sda_v};
            r.scl = scl_v;
            r.sda_out = sda_v;
            r.ack_missing = nack;
            expected_q.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result %0d arrived with nothing expected: %h", results_seen, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.scl !== want.scl || got.sda_out !== want.sda_out ||
                got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                got.key_valid !== want.key_valid || got.key_code !== want.key_code ||
                got.ack_missing !== want.ack_missing) begin
                failures++;
                if (failures <= 10) begin
                    $display("result %0d mismatch", results_seen);
                    $display("  expected scl=%b sda=%b busy=%b done=%b kv=%b key=%h nack=%b",
                             want.scl, want.sda_out, want.busy_res, want.done_res,
                             want.key_valid, want.key_code, want.ack_missing);
                    $display("  actual   scl=%b sda=%b busy=%b done=%b kv=%b key=%h nack=%b",
                             got.scl, got.sda_out, got.busy_res, got.done_res,
                             got.key_valid, got.key_code, got.ack_missing);
                end
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    logic [7:0] cfg_data;

    tick_scoreboard board = new();
    int ticks_sent = 0;
    bit sender_idles = 1'b0;
    bit receiver_quiet = 1'b0;
    bit hold_pending = 1'b0;

    led_keypad_two_wire_master uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_data);
    end

    initial begin : receiver
        int n;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_ready <= 1'b0;
                for (n = 0; n < 300; n++)
                    @(posedge aclk);
            end else if (!receiver_quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic offer_tick(in_item_t it);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        board.note_tick(it);
        ticks_sent++;
    endtask

    task automatic idle_ticks(int count);
        logic [ItemBits-1:0] raw;
        in_item_t it;
        repeat (count) begin
            raw = ItemBits'($urandom);
            it = raw;
            it.op = OP_TICK;
            offer_tick(it);
        end
    endtask

    task automatic run_transaction(op_t op, logic [1:0] digit, logic [7:0] pattern,
                                   ack_mode_t acks);
        logic [ItemBits-1:0] raw;
        in_item_t it;
        int length;
        length = (op == OP_READ_KEYS) ? int'(LAST_READ) + 1 : int'(LAST_WRITE) + 1;
        for (int k = 0; k < length; k++) begin
            raw = ItemBits'($urandom);
            it = raw;
            if (k == 0) begin
                it.op = op;
                it.digit = digit;
                it.segment_pattern = pattern;
            end
            // ack sample ticks of the first and second byte
            if ((k == 27 || k == 54) && acks != ACKS_RANDOM)
                it.sda_in = (acks == ACKS_HIGH);
            offer_tick(it);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_settings(logic [7:0] b, logic [7:0] seg, logic [7:0] lp,
                                  logic [7:0] on);
        logic [7:0] vals[4];
        cfg_index_t idx;
        vals = '{b, seg, lp, on};
        drain_results();
        idx = CFG_BRIGHTNESS;
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            board.write_reg(idx, vals[i]);
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        op_t op;
        int  pick;
        bit  hold_done;
        hold_done = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BRIGHTNESS;
        cfg_data <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        write_settings(8'd0, 8'd0, 8'd0, 8'd0);
        idle_ticks(3);
        run_transaction(OP_SETTINGS, 2'd0, 8'h00, ACKS_LOW);
        write_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_transaction(OP_SETTINGS, 2'd3, 8'hFF, ACKS_LOW);
        run_transaction(OP_WRITE_DIGIT, 2'd0, 8'h00, ACKS_LOW);
        run_transaction(OP_WRITE_DIGIT, 2'd3, 8'hFF, ACKS_HIGH);
        idle_ticks(2);
        run_transaction(OP_READ_KEYS, 2'd1, 8'hA5, ACKS_LOW);
        run_transaction(OP_READ_KEYS, 2'd2, 8'h5A, ACKS_HIGH);
        write_settings(8'd5, 8'd0, 8'd1, 8'd0);
        run_transaction(OP_SETTINGS, 2'd1, 8'h3C, ACKS_RANDOM);

        // random part
        while (ticks_sent < 900) begin
            if (ticks_sent > 750) begin
                sender_idles = 1'b0;
                receiver_quiet = 1'b1;
            end else begin
                sender_idles = ($urandom_range(0, 2) != 0);
            end
            if (!hold_done && ticks_sent >= 450) begin
                hold_done = 1'b1;
                hold_pending = 1'b1;
                sender_idles = 1'b0;
            end
            if ($urandom_range(0, 5) == 0)
                write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            op = op_t'($urandom_range(1, 3));
            pick = $urandom_range(0, 9);
            run_transaction(op, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            pick < 7 ? ACKS_LOW : (pick < 9 ? ACKS_RANDOM : ACKS_HIGH));
            idle_ticks($urandom_range(0, 3));
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (board.failures == 0 && board.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
